// ----- hdl/lgs_pkg.sv -----
// shared types and constants for the life generation step block
`default_nettype none

package lgs_pkg;

   localparam int ROW_WIDTH_DEF = 64;
   localparam int CFG_W = 7;
   localparam logic [CFG_W-1:0] NUM_COLS_RESET = 7'd64;

   localparam int NBR_W = 4;
   localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
   localparam logic [NBR_W-1:0] SURVIVE_MIN = 4'd2;

   localparam int GROUP = 8;
   localparam int GROUP_CNT_W = 4;

   typedef struct packed {
      logic up;
      logic mid;
      logic down;
   } col_bits_type;

   typedef struct packed {
      logic issue;
      logic upd;
      logic shift;
      logic take;
      logic row_mid;
      logic row_down;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- hdl/lgs_req_if.sv -----
// input channel: one grid row per item
`default_nettype none

interface lgs_req_if #(
   parameter int ROW_WIDTH = lgs_pkg::ROW_WIDTH_DEF
);
   logic                 valid;
   logic                 ready;
   logic [ROW_WIDTH-1:0] row_bits;
   logic                 last_row;

   modport source (output valid, output row_bits, output last_row, input ready);
   modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

`default_nettype wire

// ----- hdl/lgs_rsp_if.sv -----
// result channel: one next-generation row per item
`default_nettype none

interface lgs_rsp_if #(
   parameter int ROW_WIDTH = lgs_pkg::ROW_WIDTH_DEF,
   parameter int CNT_W = $clog2(ROW_WIDTH + 1)
);
   logic                 valid;
   logic                 ready;
   logic [ROW_WIDTH-1:0] next_row;
   logic [CNT_W-1:0]     births;
   logic [CNT_W-1:0]     deaths;
   logic                 last;

   modport source (output valid, output next_row, output births, output deaths,
                   output last, input ready);
   modport sink (input valid, input next_row, input births, input deaths,
                 input last, output ready);
endinterface

`default_nettype wire

// ----- hdl/lgs_cell.sv -----
// one grid column: holds the two pending rows and applies the b3/s23 rule
`default_nettype none

module lgs_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lgs_pkg::cell_ctrl_type ctrl,
   input  wire logic                  row_bit,
   input  wire logic                  live,
   input  wire lgs_pkg::col_bits_type left,
   input  wire lgs_pkg::col_bits_type right,
   output lgs_pkg::col_bits_type      own,
   output logic                       next_bit,
   output logic                       born_bit,
   output logic                       died_bit
);

   localparam int NW = lgs_pkg::NBR_W;

   logic          above_ff;
   logic          above_in;
   logic          middle_ff;
   logic          middle_in;
   logic          next_ff;
   logic          born_ff;
   logic          died_ff;
   logic          up_b;
   logic          mid_b;
   logic          down_b;
   logic [NW-1:0] cnt;
   logic          nx;

   always_comb begin
      up_b   = ctrl.row_mid ? 1'b0 : above_ff;
      mid_b  = ctrl.row_mid ? row_bit : middle_ff;
      down_b = ctrl.row_down ? row_bit : 1'b0;
      own.up   = up_b & live;
      own.mid  = mid_b & live;
      own.down = down_b & live;
      cnt = NW'(left.up) + NW'(left.mid) + NW'(left.down)
          + NW'(right.up) + NW'(right.mid) + NW'(right.down)
          + NW'(own.up) + NW'(own.down);
      nx = live & ((cnt == lgs_pkg::BIRTH_COUNT) |
                   (own.mid & (cnt == lgs_pkg::SURVIVE_MIN)));
      above_in  = ctrl.shift ? middle_ff : 1'b0;
      middle_in = ctrl.take ? row_bit : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else if (ctrl.upd) begin
         above_ff  <= above_in;
         middle_ff <= middle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         next_ff <= nx;
         born_ff <= nx & ~own.mid;
         died_ff <= ~nx & own.mid;
      end
   end

   assign next_bit = next_ff;
   assign born_bit = born_ff;
   assign died_bit = died_ff;

endmodule

`default_nettype wire

// ----- hdl/lgs_popcnt.sv -----
// two-stage population count: byte group sums, then their total
`default_nettype none

module lgs_popcnt #(
   parameter int WIDTH = lgs_pkg::ROW_WIDTH_DEF,
   parameter int CNT_W = $clog2(WIDTH + 1)
) (
   input  wire logic             clock,
   input  wire logic [WIDTH-1:0] bits,
   input  wire logic             en_a,
   input  wire logic             en_b,
   output logic      [CNT_W-1:0] count
);

   localparam int G = lgs_pkg::GROUP;
   localparam int GW = lgs_pkg::GROUP_CNT_W;
   localparam int GROUPS = (WIDTH + G - 1) / G;
   localparam int PAD_W = GROUPS * G;

   logic [PAD_W-1:0]  padded;
   logic [GW-1:0]     part_in [GROUPS];
   logic [GW-1:0]     part_ff [GROUPS];
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  count_ff;

   assign padded = PAD_W'(bits);

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         part_in[g] = '0;
         for (int b = 0; b < G; b++) begin
            part_in[g] = part_in[g] + GW'(padded[g*G + b]);
         end
      end
      count_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         count_in = count_in + CNT_W'(part_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         part_ff <= part_in;
      end
      if (en_b) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

`default_nettype wire

// ----- hdl/life_generation_step.sv -----
// life_generation_step: one b3/s23 generation over a non-wrapping grid, one row per item
//
// req_chan carries one grid row (row_bits, last_row) per item; rsp_chan returns the
// next-generation row with its birth and death counts and a last flag. csr_we/csr_wdata
// write num_cols, the number of live columns (reset 64); write it only while idle.
// A row column is held in each cell of a chain of ROW_WIDTH cells, which also hold the
// two pending rows and trade their bits with both neighbors.
// The first row of a grid gives no result unless it is last. Each later row gives the
// result for the row above it; a last row after earlier rows gives two results, the
// second with last set, and then blocks the input while it flushes.
// A result moves through the cell stage, the group count stage and the output register
// after the item that completes it is accepted; the flushed last result takes that
// path too. Throughput: one item per cycle unless the receiver stalls, set by the cell row
// which evaluates one row per cycle; a last row also holds the input during its flush.
// Reset (synchronous, active high) empties the pipeline and the pending rows and sets
// num_cols to 64. When the receiver stalls the three stages fill and hold, then
// req_chan.ready drops; the output register holds its item until taken.
`default_nettype none

module life_generation_step #(
   parameter int ROW_WIDTH = lgs_pkg::ROW_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lgs_req_if.sink                            req_chan,
   lgs_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [lgs_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int CW = lgs_pkg::CFG_W;
   localparam int CNT_W = $clog2(ROW_WIDTH + 1);

   logic [CW-1:0]         num_cols_ff;
   logic                  held_ff;
   logic                  held_in;
   logic                  flush_ff;
   logic                  flush_in;
   logic                  accept;
   logic                  issue;
   logic                  last_in;
   lgs_pkg::cell_ctrl_type ctrl;

   logic [ROW_WIDTH-1:0]  live_vec;
   lgs_pkg::col_bits_type col [ROW_WIDTH];
   logic [ROW_WIDTH-1:0]  s1_next;
   logic [ROW_WIDTH-1:0]  s1_born;
   logic [ROW_WIDTH-1:0]  s1_died;

   logic                  s1_valid_ff;
   logic                  s1_last_ff;
   logic                  s2_valid_ff;
   logic                  s2_last_ff;
   logic [ROW_WIDTH-1:0]  s2_next_ff;
   logic                  s3_valid_ff;
   logic                  s3_last_ff;
   logic [ROW_WIDTH-1:0]  s3_next_ff;
   logic                  s1_ready;
   logic                  s2_ready;
   logic                  s3_ready;
   logic [CNT_W-1:0]      births_cnt;
   logic [CNT_W-1:0]      deaths_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff <= lgs_pkg::NUM_COLS_RESET;
      end else if (csr_we) begin
         num_cols_ff <= csr_wdata;
      end
   end

   // pipeline handshake
   assign s3_ready = ~s3_valid_ff | rsp_chan.ready;
   assign s2_ready = ~s2_valid_ff | s3_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;

   assign req_chan.ready = s1_ready & ~flush_ff;
   assign accept = req_chan.valid & req_chan.ready;

   always_comb begin
      issue = (accept & (held_ff | req_chan.last_row)) | (flush_ff & s1_ready);
      last_in = flush_ff | (req_chan.last_row & ~held_ff);
      ctrl.issue    = issue;
      ctrl.upd      = accept | (flush_ff & s1_ready);
      ctrl.shift    = accept & held_ff;
      ctrl.take     = accept & ~(req_chan.last_row & ~held_ff);
      ctrl.row_mid  = ~flush_ff & ~held_ff;
      ctrl.row_down = ~flush_ff & held_ff;
      held_in  = held_ff;
      flush_in = flush_ff;
      if (flush_ff && s1_ready) begin
         held_in  = 1'b0;
         flush_in = 1'b0;
      end else if (accept) begin
         held_in  = ~req_chan.last_row | held_ff;
         flush_in = req_chan.last_row & held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         flush_ff <= 1'b0;
      end else begin
         held_ff  <= held_in;
         flush_ff <= flush_in;
      end
   end

   for (genvar c = 0; c < ROW_WIDTH; c++) begin : g_cell
      lgs_pkg::col_bits_type left_bits;
      lgs_pkg::col_bits_type right_bits;

      assign live_vec[c] = (num_cols_ff > CW'(c));

      if (c == 0) begin : g_left_edge
         assign left_bits = '0;
      end else begin : g_left
         assign left_bits = col[c-1];
      end
      if (c == ROW_WIDTH - 1) begin : g_right_edge
         assign right_bits = '0;
      end else begin : g_right
         assign right_bits = col[c+1];
      end

      lgs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .row_bit  (req_chan.row_bits[c]),
         .live     (live_vec[c]),
         .left     (left_bits),
         .right    (right_bits),
         .own      (col[c]),
         .next_bit (s1_next[c]),
         .born_bit (s1_born[c]),
         .died_bit (s1_died[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= issue;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_last_ff <= last_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_last_ff <= s1_last_ff;
         s2_next_ff <= s1_next;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_last_ff <= s2_last_ff;
         s3_next_ff <= s2_next_ff;
      end
   end

   lgs_popcnt #(
      .WIDTH (ROW_WIDTH),
      .CNT_W (CNT_W)
   ) u_births (
      .clock (clock),
      .bits  (s1_born),
      .en_a  (s1_valid_ff & s2_ready),
      .en_b  (s2_valid_ff & s3_ready),
      .count (births_cnt)
   );

   lgs_popcnt #(
      .WIDTH (ROW_WIDTH),
      .CNT_W (CNT_W)
   ) u_deaths (
      .clock (clock),
      .bits  (s1_died),
      .en_a  (s1_valid_ff & s2_ready),
      .en_b  (s2_valid_ff & s3_ready),
      .count (deaths_cnt)
   );

   assign rsp_chan.valid    = s3_valid_ff;
   assign rsp_chan.next_row = s3_next_ff;
   assign rsp_chan.births   = births_cnt;
   assign rsp_chan.deaths   = deaths_cnt;
   assign rsp_chan.last     = s3_last_ff;

   a_flush_blocks_input: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> !req_chan.ready)
      else $error("input taken during flush");

   a_last_sets_flush: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.last_row && held_ff |=> flush_ff)
      else $error("last row after pending row did not start flush");

   a_flush_issues_last: assert property (@(posedge clock) disable iff (reset)
      flush_ff && s1_ready |=> s1_valid_ff && s1_last_ff && !flush_ff && !held_ff)
      else $error("flush did not issue the last result");

   a_cell_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_next))
      else $error("cell stage lost its row while stalled");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// testbench for life_generation_step: random grids checked against a b3/s23 row predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RW = lgs_pkg::ROW_WIDTH_DEF;
   localparam int CFG_W = lgs_pkg::CFG_W;
   localparam int CW = $clog2(RW + 1);
   localparam int TOTAL_ROWS = 1800;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [RW-1:0] row_bits;
      logic          last_row;
   } grid_row_type;

   typedef struct {
      logic [RW-1:0] next_row;
      logic [CW-1:0] births;
      logic [CW-1:0] deaths;
      logic          last;
   } gen_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   lgs_req_if #(.ROW_WIDTH(RW)) req_chan ();
   lgs_rsp_if #(.ROW_WIDTH(RW)) rsp_chan ();

   life_generation_step #(.ROW_WIDTH(RW)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [CFG_W-1:0] life_cols = lgs_pkg::NUM_COLS_RESET;
   logic [RW-1:0]    band_above = '0;
   logic [RW-1:0]    band_mid = '0;
   logic [1:0]       band_held = '0;
   gen_row_type      next_gen_q[$];

   grid_row_type     pending_rows[$];
   grid_row_type     drv_row;
   gen_row_type      mon_want;
   int               send_gap = 0;
   int               recv_gap = 0;
   bit               send_idle_on = 1'b1;
   bit               recv_idle_on = 1'b1;
   int               hold_ticket = 0;
   int               hold_served = 0;
   int               err_count = 0;
   int               rows_taken = 0;
   int               results_seen = 0;
   int               rows_loaded = 0;
   int               grids_loaded = 0;
   int               widths_used = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.row_bits = '0;
      req_chan.last_row = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   function automatic gen_row_type life_rule_row(logic [RW-1:0] up, logic [RW-1:0] mid,
                                                 logic [RW-1:0] down, logic is_last);
      gen_row_type   res;
      logic [RW-1:0] live;
      int            width;
      int            cnt;
      logic          nx;
      width = (life_cols > RW) ? RW : int'(life_cols);
      live = (width >= RW) ? '1 : ((RW'(1) << width) - RW'(1));
      up &= live;
      mid &= live;
      down &= live;
      res.next_row = '0;
      res.births = '0;
      res.deaths = '0;
      res.last = is_last;
      for (int c = 0; c < RW; c++) begin
         cnt = up[c] + down[c];
         if (c > 0) cnt += up[c-1] + mid[c-1] + down[c-1];
         if (c < RW - 1) cnt += up[c+1] + mid[c+1] + down[c+1];
         if (mid[c]) nx = (cnt >= lgs_pkg::SURVIVE_MIN && cnt <= lgs_pkg::BIRTH_COUNT);
         else nx = (cnt == lgs_pkg::BIRTH_COUNT);
         if (!live[c]) nx = 1'b0;
         res.next_row[c] = nx;
         if (nx && !mid[c]) res.births++;
         if (!nx && mid[c]) res.deaths++;
      end
      return res;
   endfunction

   task automatic take_row(logic [RW-1:0] row, logic last_row);
      if (band_held != 0) begin
         next_gen_q.push_back(life_rule_row(band_above, band_mid, row, 1'b0));
         band_above = band_mid;
      end else begin
         band_above = '0;
      end
      band_mid = row;
      band_held = (band_held == 0) ? 2'd1 : 2'd2;
      if (last_row) begin
         next_gen_q.push_back(life_rule_row(band_above, band_mid, '0, 1'b1));
         band_above = '0;
         band_mid = '0;
         band_held = '0;
      end
   endtask

   task automatic report_mismatch(string what, logic [RW-1:0] got, logic [RW-1:0] want);
      err_count++;
      $display("tb_top: mismatch on %s at result %0d: got %h, want %h",
               what, results_seen, got, want);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 90) return $urandom_range(1, 3);
      else return $urandom_range(4, 24);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            take_row(req_chan.row_bits, req_chan.last_row);
            rows_taken++;
         end
         if (send_gap != 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_rows.size() != 0) begin
            drv_row = pending_rows.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.row_bits <= drv_row.row_bits;
            req_chan.last_row <= drv_row.last_row;
            send_gap = send_idle_on ? pick_gap() : 0;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (next_gen_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_chan.next_row, '0);
            end else begin
               mon_want = next_gen_q.pop_front();
               if (rsp_chan.next_row !== mon_want.next_row)
                  report_mismatch("next_row", rsp_chan.next_row, mon_want.next_row);
               if (rsp_chan.births !== mon_want.births)
                  report_mismatch("births", RW'(rsp_chan.births), RW'(mon_want.births));
               if (rsp_chan.deaths !== mon_want.deaths)
                  report_mismatch("deaths", RW'(rsp_chan.deaths), RW'(mon_want.deaths));
               if (rsp_chan.last !== mon_want.last)
                  report_mismatch("last", RW'(rsp_chan.last), RW'(mon_want.last));
            end
            results_seen++;
         end
         if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            recv_gap = HOLD_CYCLES;
         end else if (recv_gap == 0 && recv_idle_on && $urandom_range(0, 2) == 0) begin
            recv_gap = pick_gap();
         end
         if (recv_gap != 0) begin
            recv_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic wait_settled();
      do @(negedge clock);
      while (pending_rows.size() != 0 || req_chan.valid || next_gen_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_cols(logic [CFG_W-1:0] cols);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= cols;
      life_cols = cols;
      @(posedge clock);
      csr_we <= 1'b0;
      widths_used++;
      @(negedge clock);
   endtask

   task automatic load_row(logic [RW-1:0] bits, logic last_row);
      grid_row_type r;
      r.row_bits = bits;
      r.last_row = last_row;
      pending_rows.push_back(r);
      rows_loaded++;
      if (last_row) grids_loaded++;
   endtask

   function automatic logic [RW-1:0] pick_row();
      logic [RW-1:0] a;
      logic [RW-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4: return a;
         5, 6: return a & b;
         7: return a | b;
         8: return a & b & {$urandom, $urandom};
         default: return RW'(64'h7) << $urandom_range(0, RW - 3);
      endcase
   endfunction

   task automatic load_grid(int height);
      for (int i = 0; i < height; i++) load_row(pick_row(), i == height - 1);
   endtask

   function automatic int pick_height();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 1;
      else if (roll < 85) return $urandom_range(2, 8);
      else return $urandom_range(9, 40);
   endfunction

   initial begin
      logic [CFG_W-1:0] edge_widths[8];
      logic [CFG_W-1:0] cols;
      int               phase_no;
      int               phase_rows;
      int               grid_h;
      edge_widths = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65, 7'd127};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-row grids, blinker, full and checker grids, edge columns
      load_row('1, 1'b1);
      load_row('0, 1'b1);
      load_row(RW'(1) << 4, 1'b0);
      load_row(RW'(1) << 4, 1'b0);
      load_row(RW'(1) << 4, 1'b1);
      load_row('1, 1'b0);
      load_row('1, 1'b0);
      load_row('1, 1'b1);
      load_row({(RW/2){2'b10}}, 1'b0);
      load_row({(RW/2){2'b01}}, 1'b0);
      load_row({(RW/2){2'b10}}, 1'b1);
      load_row({2'b11, {(RW-4){1'b0}}, 2'b11}, 1'b0);
      load_row({2'b10, {(RW-4){1'b0}}, 2'b01}, 1'b0);
      load_row({2'b11, {(RW-4){1'b0}}, 2'b11}, 1'b1);
      wait_settled();
      write_cols(7'd0);
      load_row('1, 1'b0);
      load_row('1, 1'b1);
      wait_settled();
      write_cols(7'd127);
      load_row({$urandom, $urandom}, 1'b0);
      load_row({$urandom, $urandom}, 1'b1);
      wait_settled();
      write_cols(7'd1);
      load_row('1, 1'b0);
      load_row('1, 1'b1);
      wait_settled();
      // width change with rows still pending
      write_cols(7'd64);
      load_row('1, 1'b0);
      load_row('1, 1'b0);
      wait_settled();
      write_cols(7'd10);
      load_row('1, 1'b1);

      phase_no = 0;
      while (rows_loaded < TOTAL_ROWS) begin
         wait_settled();
         if (phase_no < 8) cols = edge_widths[phase_no];
         else if ($urandom_range(0, 3) == 0) cols = edge_widths[$urandom_range(0, 7)];
         else cols = CFG_W'($urandom_range(1, RW));
         write_cols(cols);
         send_idle_on = ($urandom_range(0, 3) != 0);
         recv_idle_on = ($urandom_range(0, 3) != 0);
         if (phase_no % 4 == 3) begin
            send_idle_on = 1'b0;
            recv_idle_on = 1'b0;
         end
         if (phase_no == 2 || phase_no == 11) send_idle_on = 1'b0;
         phase_rows = 0;
         while (phase_rows < 100) begin
            grid_h = pick_height();
            load_grid(grid_h);
            phase_rows += grid_h;
         end
         if (phase_no == 2 || phase_no == 11) hold_ticket++;
         phase_no++;
      end

      wait_settled();
      if (next_gen_q.size() != 0)
         report_mismatch("missing items", RW'(next_gen_q.size()), '0);
      $display("tb_top: %0d rows in %0d grids accepted, %0d result rows checked",
               rows_taken, grids_loaded, results_seen);
      $display("tb_top: %0d column width settings, %0d long receiver holds",
               widths_used, hold_served);
      if (err_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb_top: timeout");
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
